// ===== src/adaptive_prefetch_distance_unit_assert.svh =====
// Assertion macros for the adaptive prefetch distance unit.
// They expect signals named clk and arst_n in the scope of use.
`ifndef ADAPTIVE_PREFETCH_DISTANCE_UNIT_ASSERT_SVH
`define ADAPTIVE_PREFETCH_DISTANCE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define APD_ASSERT(lbl, prop) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error("apd check failed");
`define APD_NEVER(lbl, expr) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error("apd check failed");
`else
`define APD_ASSERT(lbl, prop)
`define APD_NEVER(lbl, expr)
`endif
`endif

// ===== src/apd_pkg.sv =====
package apd_pkg;

	localparam int RING_DEPTH = 16;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int FILL_W     = $clog2(RING_DEPTH + 1);
	localparam int DIST_W     = 10;
	localparam int LAT_W      = 24;
	localparam int RUN_W      = 10;
	localparam int SCALE_W    = 26;
	localparam int FRAC_W     = 16;
	localparam int TPUT_MUL   = 1000;
	localparam int NUM_W      = DIST_W + SCALE_W;
	localparam int SD_W       = DIST_W + IDX_W + 1;
	localparam int ST_W       = NUM_W + IDX_W + 1;
	localparam int PROD_W     = NUM_W + FILL_W;
	localparam int CMP_W      = PROD_W + 5;
	localparam int FB_MUL     = 7;
	localparam int FB_RECIP   = 52429;
	localparam int FB_SHIFT   = 19;
	localparam int FB_PROD_W  = DIST_W + FB_SHIFT;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [RUN_W-1:0]  RUN_MAX  = {RUN_W{1'b1}};

	localparam logic [1:0] CFG_RING_ENABLE  = 2'd0;
	localparam logic [1:0] CFG_LOW_MARK     = 2'd1;
	localparam logic [1:0] CFG_HIGH_MARK    = 2'd2;
	localparam logic [1:0] CFG_MAX_DISTANCE = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRD,
		ST_WDIV,
		ST_WWAIT,
		ST_IODIV,
		ST_IOWAIT,
		ST_MUL,
		ST_CMP,
		ST_UPCHK,
		ST_DNCHK,
		ST_CLAMP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [LAT_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

// ===== src/apd_div.sv =====
module apd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  apd_pkg::div_req_t req,
	output apd_pkg::div_rsp_t rsp
);
	import apd_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] q_q;
	logic [LAT_W-1:0] rem_q;
	logic [LAT_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [LAT_W:0]   shifted;
	logic [LAT_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, q_q[NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q   <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[LAT_W-1:0] : shifted[LAT_W-1:0];
			q_q   <= {q_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = q_q;

endmodule

// ===== src/adaptive_prefetch_distance_unit.sv =====
// Flow: record, cached-read, empty-ring and disabled beats go from acceptance straight to the
// result stage. Adjust beats with history run one division per valid ring entry, up to a full
// ring of 16 entries, then one for the beat itself; a stalled result adds its wait.
// Throughput: one beat at a time, the next accepted once the unit is back in idle after the
// result is loaded; every throughput term goes through the shared 36-step radix-2 divider.
// Reset: asynchronous, active low; clears control state, the ring reads as empty.
`include "adaptive_prefetch_distance_unit_assert.svh"

module adaptive_prefetch_distance_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [apd_pkg::DIST_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         mode,
	input  logic [apd_pkg::DIST_W-1:0]   done_count,
	input  logic                         real_io,
	input  logic [apd_pkg::DIST_W-1:0]   io_distance,
	input  logic [apd_pkg::LAT_W-1:0]    latency_us,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [apd_pkg::DIST_W-1:0]   distance,
	output logic                         changed,
	output logic                         calculated
);
	import apd_pkg::*;

	state_t state_q, state_d;

	logic              ring_enable_q;
	logic [DIST_W-1:0] low_mark_q, high_mark_q, max_dist_q;
	logic [DIST_W-1:0] cur_q, flip_q, d_q, cap_q, mx_q, iod_q;
	logic [RUN_W-1:0]  up_q, down_q;
	logic              cap_valid_q, calc_q, above_q;
	logic [IDX_W-1:0]  pos_q, pos_next, rd_addr;
	logic [FILL_W-1:0] fill_q, k_q;
	logic [SD_W-1:0]   sd_q;
	logic [ST_W-1:0]   st_q;
	logic [NUM_W-1:0]  io_t_q;
	logic [PROD_W-1:0] prod_q;
	logic [LAT_W-1:0]  lat_q;
	logic              out_valid_q, changed_q, calc_out_q;
	logic [DIST_W-1:0] dist_out_q;

	logic [LAT_W-1:0]  lat_mem [RING_DEPTH];
	logic [DIST_W-1:0] dist_mem [RING_DEPTH];
	logic [LAT_W-1:0]  rd_lat_q;
	logic [DIST_W-1:0] rd_dist_q;

	logic              accept, out_free, good, up_reach, dn_reach;
	logic [DIST_W:0]   nudge1, nudge2;
	logic [DIST_W-1:0] nudge, clamp_t1, clamp_t2, clamp_t3, clamp_d, cap_inc_min, mx_min;
	logic [DIST_W:0]   cap_inc;
	logic [CMP_W-1:0]  lhs, rhs;
	logic [FB_PROD_W-1:0] fb_prod;
	logic [DIST_W-1:0] fb_d;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	apd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign pos_next = (pos_q == '0) ? IDX_W'(RING_DEPTH - 1) : pos_q - 1'b1;
	assign rd_addr  = pos_q + k_q[IDX_W-1:0];

	always_comb begin
		nudge1 = {1'b0, cur_q} + ((done_count <= low_mark_q) ? 1'b1 : 1'b0);
		nudge2 = nudge1;
		if (done_count >= high_mark_q) begin
			nudge2 = (nudge1 > (DIST_W+1)'(1)) ? nudge1 - 1'b1 : (DIST_W+1)'(1);
		end
		nudge = (nudge2 > {1'b0, DIST_MAX}) ? DIST_MAX : nudge2[DIST_W-1:0];
	end

	always_comb begin
		clamp_t1 = (d_q == '0) ? DIST_W'(1) : d_q;
		clamp_t2 = (cap_valid_q && cap_q < clamp_t1) ? cap_q : clamp_t1;
		clamp_t3 = (clamp_t2 > max_dist_q) ? max_dist_q : clamp_t2;
		clamp_d  = (clamp_t3 == '0) ? DIST_W'(1) : clamp_t3;
	end

	// The fallback distance is seven tenths of the flip point, by reciprocal multiplication.
	assign fb_prod = FB_PROD_W'(flip_q) * FB_PROD_W'(FB_MUL * FB_RECIP);
	assign fb_d    = fb_prod[FB_SHIFT +: DIST_W];

	assign lhs = (CMP_W'(prod_q) << 3) + (CMP_W'(prod_q) << 1);
	assign rhs = (CMP_W'(st_q) << 3) + (CMP_W'(st_q) << 1) + CMP_W'(st_q);
	assign good = lhs >= rhs;
	assign up_reach = (RUN_W + FILL_W)'(up_q) * (RUN_W + FILL_W)'(fill_q)
		>= (RUN_W + FILL_W)'(sd_q);
	assign dn_reach = (RUN_W + FILL_W)'(down_q) * (RUN_W + FILL_W)'(fill_q)
		>= (RUN_W + FILL_W)'(sd_q);
	assign cap_inc     = {1'b0, cap_q} + 1'b1;
	assign cap_inc_min = (cap_inc < {1'b0, max_dist_q}) ? cap_inc[DIST_W-1:0] : max_dist_q;
	assign mx_min      = (mx_q < max_dist_q) ? mx_q : max_dist_q;

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = (NUM_W'(rd_dist_q) * NUM_W'(TPUT_MUL)) << FRAC_W;
		div_req.den   = (rd_lat_q == '0) ? LAT_W'(1) : rd_lat_q;
		unique case (state_q)
			ST_WDIV: begin
				div_req.start = 1'b1;
			end
			ST_IODIV: begin
				div_req.start = 1'b1;
				div_req.num   = (NUM_W'(iod_q) * NUM_W'(TPUT_MUL)) << FRAC_W;
				div_req.den   = (lat_q == '0) ? LAT_W'(1) : lat_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (ring_enable_q && mode && real_io && fill_q != '0) begin
						state_d = ST_WRD;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_WRD:    state_d = ST_WDIV;
			ST_WDIV:   state_d = ST_WWAIT;
			ST_WWAIT: begin
				if (div_rsp.done) begin
					state_d = (k_q + 1'b1 == fill_q) ? ST_IODIV : ST_WRD;
				end
			end
			ST_IODIV:  state_d = ST_IOWAIT;
			ST_IOWAIT: begin
				if (div_rsp.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:    state_d = ST_CMP;
			ST_CMP: begin
				priority if (above_q && good) begin
					state_d = ST_UPCHK;
				end else if (above_q) begin
					state_d = ST_DNCHK;
				end else begin
					state_d = ST_CLAMP;
				end
			end
			ST_UPCHK:  state_d = ST_CLAMP;
			ST_DNCHK:  state_d = ST_CLAMP;
			ST_CLAMP:  state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_enable_q <= 1'b0;
			low_mark_q    <= DIST_W'(2);
			high_mark_q   <= DIST_W'(15);
			max_dist_q    <= DIST_W'(16);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RING_ENABLE:  ring_enable_q <= cfg_data[0];
				CFG_LOW_MARK:     low_mark_q    <= cfg_data;
				CFG_HIGH_MARK:    high_mark_q   <= cfg_data;
				CFG_MAX_DISTANCE: max_dist_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && ring_enable_q && !mode) begin
			lat_mem[pos_next]  <= latency_us;
			dist_mem[pos_next] <= io_distance;
		end
		rd_lat_q  <= lat_mem[rd_addr];
		rd_dist_q <= dist_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= DIST_W'(2);
			flip_q      <= '0;
			up_q        <= '0;
			down_q      <= '0;
			cap_valid_q <= 1'b0;
			cap_q       <= '0;
			pos_q       <= '0;
			fill_q      <= '0;
			k_q         <= '0;
			calc_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						calc_q <= 1'b0;
						k_q    <= '0;
						if (ring_enable_q && !mode) begin
							pos_q <= pos_next;
							if (fill_q != FILL_W'(RING_DEPTH)) begin
								fill_q <= fill_q + 1'b1;
							end
						end
					end
				end
				ST_WWAIT: begin
					if (div_rsp.done) begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_CMP: begin
					priority if (above_q && good) begin
						flip_q <= iod_q;
						if (up_q != RUN_MAX) begin
							up_q <= up_q + 1'b1;
						end
						down_q <= '0;
					end else if (above_q) begin
						if (down_q != RUN_MAX) begin
							down_q <= down_q + 1'b1;
						end
						up_q <= '0;
					end else begin
					end
				end
				ST_UPCHK: begin
					if (up_reach) begin
						cap_valid_q <= 1'b0;
					end else if (cap_valid_q) begin
						cap_q <= cap_inc_min;
					end
				end
				ST_DNCHK: begin
					if (dn_reach) begin
						cap_valid_q <= 1'b1;
						cap_q       <= mx_min;
					end
				end
				ST_CLAMP: begin
					calc_q <= 1'b1;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						cur_q       <= d_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					iod_q <= io_distance;
					lat_q <= latency_us;
					sd_q  <= '0;
					st_q  <= '0;
					mx_q  <= '0;
					d_q   <= (ring_enable_q && mode) ? nudge : cur_q;
				end
			end
			ST_WWAIT: begin
				if (div_rsp.done) begin
					sd_q <= sd_q + SD_W'(rd_dist_q);
					st_q <= st_q + ST_W'(div_rsp.quo);
					if (rd_dist_q > mx_q) begin
						mx_q <= rd_dist_q;
					end
				end
			end
			ST_IOWAIT: begin
				if (div_rsp.done) begin
					io_t_q <= div_rsp.quo;
				end
			end
			ST_MUL: begin
				prod_q  <= PROD_W'(io_t_q) * PROD_W'(fill_q);
				above_q <= (SD_W'(iod_q) * SD_W'(fill_q)) > sd_q;
			end
			ST_DNCHK: begin
				if (dn_reach) begin
					d_q <= (fb_d != '0) ? fb_d - 1'b1 : '0;
				end else begin
					d_q <= (d_q != '0) ? d_q - 1'b1 : '0;
				end
			end
			ST_CLAMP: begin
				d_q <= clamp_d;
			end
			ST_FIN: begin
				if (out_free) begin
					dist_out_q <= d_q;
					changed_q  <= (d_q != cur_q);
					calc_out_q <= calc_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign distance   = dist_out_q;
	assign changed    = changed_q;
	assign calculated = calc_out_q;

	`APD_NEVER(a_fill_bound, fill_q > FILL_W'(RING_DEPTH))
	`APD_ASSERT(a_walk_in_fill, (state_q == ST_WRD) |-> (k_q < fill_q))
	`APD_NEVER(a_dist_nonzero, out_valid_q && dist_out_q == '0)
	`APD_ASSERT(a_calc_clamped, (out_valid_q && calc_out_q) |-> (dist_out_q <= max_dist_q || max_dist_q == '0))

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import apd_pkg::*;

	typedef struct packed {
		logic             mode;
		logic [DIST_W-1:0] ccount;
		logic             real_io;
		logic [DIST_W-1:0] iod;
		logic [LAT_W-1:0] lat;
	} beat_t;

	typedef struct packed {
		logic [DIST_W-1:0] dval;
		logic             chg;
		logic             calc;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_RING_ENABLE;
	logic [DIST_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = 1'b0;
	logic [DIST_W-1:0] done_count = '0;
	logic real_io = 1'b0;
	logic [DIST_W-1:0] io_distance = '0;
	logic [LAT_W-1:0] latency_us = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DIST_W-1:0] distance;
	logic changed;
	logic calculated;

	adaptive_prefetch_distance_unit dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor state.
	logic        p_en;
	logic [9:0]  p_low, p_high, p_max;
	logic [9:0]  p_cur, p_flip, p_up, p_down;
	int          p_cap;
	logic [23:0] p_rlat [RING_DEPTH];
	logic [9:0]  p_rdist [RING_DEPTH];
	int          p_pos, p_fill;

	beat_t pending[$];
	res_t  expected_res[$];
	int    errors = 0;
	int    n_res = 0;
	int    n_calc = 0;
	bit    quiet = 0;
	bit    hold = 0;
	int    hold_cnt = 0;
	bit    no_idle = 0;
	int    in_gap = 0;
	int    out_gap = 0;

	function automatic longint unsigned tput(logic [9:0] d, logic [23:0] l);
		longint unsigned ll;
		ll = (l == 0) ? 1 : l;
		return (longint'(d) * 1000 * 65536) / ll;
	endfunction

	function automatic void predictor_cfg(logic [1:0] idx, logic [9:0] v);
		case (idx)
			CFG_RING_ENABLE:  p_en = v[0];
			CFG_LOW_MARK:     p_low = v;
			CFG_HIGH_MARK:    p_high = v;
			CFG_MAX_DISTANCE: p_max = v;
			default: ;
		endcase
	endfunction

	function automatic res_t predict_distance(beat_t b);
		res_t r;
		logic [9:0] init;
		int unsigned d;
		longint unsigned n, sd, st, io_t;
		int unsigned mx;
		int ix;
		bit above, good;
		init = p_cur;
		r.calc = 1'b0;
		if (p_en && !b.mode) begin
			p_pos = (p_pos == 0) ? RING_DEPTH - 1 : p_pos - 1;
			p_rlat[p_pos] = b.lat;
			p_rdist[p_pos] = b.iod;
			if (p_fill < RING_DEPTH)
				p_fill++;
		end else if (p_en && b.mode) begin
			d = p_cur;
			if (b.ccount <= p_low)
				d = d + 1;
			if (b.ccount >= p_high)
				d = (d > 1) ? d - 1 : 1;
			if (d > 1023)
				d = 1023;
			if (b.real_io && p_fill > 0) begin
				n = p_fill;
				sd = 0;
				st = 0;
				mx = 0;
				for (int k = 0; k < p_fill; k++) begin
					ix = (p_pos + k) % RING_DEPTH;
					sd += p_rdist[ix];
					st += tput(p_rdist[ix], p_rlat[ix]);
					if (p_rdist[ix] > mx)
						mx = p_rdist[ix];
				end
				io_t = tput(b.iod, b.lat);
				r.calc = 1'b1;
				above = longint'(b.iod) * n > sd;
				good = 10 * io_t * n >= 11 * st;
				if (above && good) begin
					p_flip = b.iod;
					if (p_up < 1023)
						p_up++;
					p_down = 0;
					if (longint'(p_up) * n >= sd)
						p_cap = -1;
					if (p_cap >= 0)
						p_cap = (p_cap + 1 < p_max) ? p_cap + 1 : p_max;
				end else if (above) begin
					if (p_down < 1023)
						p_down++;
					p_up = 0;
					if (longint'(p_down) * n >= sd) begin
						p_cap = (mx < p_max) ? mx : p_max;
						d = (int'(p_flip) * 7) / 10;
					end
					d = (d > 0) ? d - 1 : 0;
				end
				if (d < 1)
					d = 1;
				if (p_cap >= 0 && p_cap < d)
					d = p_cap;
				if (d > p_max)
					d = p_max;
				if (d < 1)
					d = 1;
				if (d > 1023)
					d = 1023;
			end
			p_cur = d[9:0];
		end
		r.dval = p_cur;
		r.chg = (p_cur != init);
		return r;
	endfunction

	// Driver.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_res.push_back(predict_distance({mode, done_count, real_io,
				io_distance, latency_us}));
		end
		if (!in_valid || in_ready) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending.size() > 0 && !no_idle && $urandom_range(0, 4) == 0) begin
				in_valid <= 1'b0;
				in_gap <= int'($urandom_range(0, 2));
			end else if (pending.size() > 0) begin
				beat_t b;
				b = pending.pop_front();
				in_valid <= 1'b1;
				mode <= b.mode;
				done_count <= b.ccount;
				real_io <= b.real_io;
				io_distance <= b.iod;
				latency_us <= b.lat;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			res_t e;
			if (expected_res.size() == 0) begin
				$display("%0t: unexpected result distance=%0d", $time, distance);
				errors++;
			end else begin
				e = expected_res.pop_front();
				n_res++;
				if (calculated)
					n_calc++;
				if (distance !== e.dval) begin
					$display("%0t: distance expected %0d actual %0d", $time, e.dval, distance);
					errors++;
				end
				if (changed !== e.chg) begin
					$display("%0t: changed expected %0b actual %0b", $time, e.chg, changed);
					errors++;
				end
				if (calculated !== e.calc) begin
					$display("%0t: calculated expected %0b actual %0b", $time, e.calc,
						calculated);
					errors++;
				end
			end
		end
		if (hold) begin
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_ready <= 1'b0;
			out_gap <= out_gap - 1;
		end else if (!no_idle && $urandom_range(0, 4) == 0) begin
			out_ready <= 1'b0;
			out_gap <= int'($urandom_range(0, 2));
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Length of the receiver hold-off.
	always @(posedge clk) begin
		if (hold)
			hold_cnt <= hold_cnt + 1;
	end

	task automatic write_reg(logic [1:0] idx, logic [9:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		predictor_cfg(idx, v);
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (pending.size() > 0 || in_valid || expected_res.size() > 0);
		repeat (20) @(posedge clk);
	endtask

	function automatic beat_t rand_beat(bit small_ring);
		beat_t b;
		b.mode = $urandom_range(0, 2) == 0;
		b.ccount = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 20));
		b.real_io = $urandom_range(0, 4) != 0;
		b.iod = ($urandom_range(0, 5) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
		case ($urandom_range(0, 3))
			0: b.lat = 24'($urandom);
			1: b.lat = 24'($urandom_range(0, 3));
			default: b.lat = 24'($urandom_range(50, 5000));
		endcase
		if (small_ring && b.mode == 1'b0 && $urandom_range(0, 1))
			b.mode = 1'b1;
		return b;
	endfunction

	function automatic beat_t mk(logic m, logic [9:0] c, logic r, logic [9:0] i,
		logic [23:0] l);
		return {m, c, r, i, l};
	endfunction

	initial begin
		p_en = 0; p_low = 2; p_high = 15; p_max = 16;
		p_cur = 2; p_flip = 0; p_up = 0; p_down = 0; p_cap = -1;
		p_pos = 0; p_fill = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Disabled history: every beat is a no-op.
		pending.push_back(mk(1, 0, 1, 5, 100));
		pending.push_back(mk(0, 0, 1, 5, 100));
		pending.push_back(mk(1, 0, 1, 0, 0));
		wait_drained();
		write_reg(CFG_RING_ENABLE, 10'd1);
		// Empty ring nudges, then extremes.
		pending.push_back(mk(1, 0, 1, 10, 100));
		pending.push_back(mk(1, 1023, 0, 10, 100));
		pending.push_back(mk(0, 0, 0, 1023, 24'hFFFFFF));
		pending.push_back(mk(0, 0, 0, 0, 0));
		pending.push_back(mk(1, 500, 1, 1023, 0));
		pending.push_back(mk(1, 500, 1, 1023, 24'hFFFFFF));
		pending.push_back(mk(0, 0, 0, 3, 1000));
		for (int i = 0; i < 6; i++)
			pending.push_back(mk(1, 500, 1, 10'(20 + i * 5), 24'(100 + i * 400)));
		pending.push_back(mk(1, 1023, 1, 0, 1));
		pending.push_back(mk(1, 0, 0, 0, 1));
		wait_drained();
		write_reg(CFG_MAX_DISTANCE, 10'd0);
		write_reg(CFG_LOW_MARK, 10'd1023);
		write_reg(CFG_HIGH_MARK, 10'd0);
		for (int i = 0; i < 8; i++)
			pending.push_back(rand_beat(0));
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_MAX_DISTANCE, (ph == 1) ? 10'd1023 : (ph == 2) ? 10'd1 :
				10'($urandom_range(4, 64)));
			write_reg(CFG_LOW_MARK, (ph == 3) ? 10'd0 : 10'($urandom_range(0, 6)));
			write_reg(CFG_HIGH_MARK, (ph == 4) ? 10'd1023 : 10'($urandom_range(5, 20)));
			write_reg(CFG_RING_ENABLE, (ph == 5) ? 10'd0 : 10'd1);
			if (ph == 7)
				no_idle = 1;
			if (ph == 2) begin
				for (int i = 0; i < 20; i++)
					pending.push_back(rand_beat(1));
				hold = 1;
				while (hold_cnt < 800)
					@(posedge clk);
				hold = 0;
			end
			for (int i = 0; i < 210; i++)
				pending.push_back(rand_beat(ph >= 6));
			wait_drained();
		end

		$display("Ran %0d results, %0d through the throughput comparison, over several",
			n_res, n_calc);
		$display("register settings including a long output stall and a disabled history.");
		if (errors == 0 && expected_res.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#200ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
